@@ rtl/rbou_pkg.sv @@
// Shared types, constants and helpers for the rigid body orientation update block.
package rbou_pkg;

  typedef enum logic [1:0] {
    SH_0,
    SH_30,
    SH_60
  } shift_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    shift_t             sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
    logic [127:0]       raw;
  } mul_rsp_t;

  localparam logic signed [63:0] ONE     = 64'sh1000_0000_0000_0000;
  localparam logic signed [31:0] UNIT30  = 32'sh4000_0000;
  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HP30    = 64'd1686629713;
  localparam logic [63:0] HP30_H  = 64'd1686629713 / 64'd2;
  localparam logic [63:0] HP60    = 64'h1921_FB54_442D_1847;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] SMALL_THR = (PI_Q30 / 64'd18) * (PI_Q30 / 64'd18);
  localparam logic [63:0] KMAX    = 64'h2000_0000_0000_0000;
  // ceil(2^78 / HP30): exact quotient for any dividend below 2^47, take product bits 127:78
  localparam logic [63:0] QRECIP  =
      64'(((128'd1 << 78) + 128'(HP30) - 128'd1) / 128'(HP30));

  localparam logic signed [63:0] SC0 = ONE;
  localparam logic signed [63:0] SC1 = -(ONE / 64'sd6);
  localparam logic signed [63:0] SC2 = ONE / 64'sd120;
  localparam logic signed [63:0] SC3 = -(ONE / 64'sd5040);
  localparam logic signed [63:0] SC4 = ONE / 64'sd362880;
  localparam logic signed [63:0] SC5 = -(ONE / 64'sd39916800);
  localparam logic signed [63:0] SC6 = ONE / 64'sd6227020800;
  localparam logic signed [63:0] CC0 = ONE / 64'sd2;
  localparam logic signed [63:0] CC1 = -(ONE / 64'sd24);
  localparam logic signed [63:0] CC2 = ONE / 64'sd720;
  localparam logic signed [63:0] CC3 = -(ONE / 64'sd40320);
  localparam logic signed [63:0] CC4 = ONE / 64'sd3628800;
  localparam logic signed [63:0] CC5 = -(ONE / 64'sd479001600);
  localparam logic signed [63:0] CC6 = ONE / 64'sd87178291200;

  function automatic logic signed [63:0] sin_coef(input logic [2:0] k);
    logic signed [63:0] c;
    unique case (k)
      3'd0: c = SC0;
      3'd1: c = SC1;
      3'd2: c = SC2;
      3'd3: c = SC3;
      3'd4: c = SC4;
      3'd5: c = SC5;
      3'd6: c = SC6;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [63:0] cos_coef(input logic [2:0] k);
    logic signed [63:0] c;
    unique case (k)
      3'd0: c = CC0;
      3'd1: c = CC1;
      3'd2: c = CC2;
      3'd3: c = CC3;
      3'd4: c = CC4;
      3'd5: c = CC5;
      3'd6: c = CC6;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

@@ rtl/rigid_body_orientation_update.sv @@
// Work: a small-angle step runs 69 multiplies on the shared multiplier, one at a time. A large-angle
// step runs 74 multiplies plus a square root and three divides on the bit-serial divider.
// Throughput: one item per step; the block takes no input while a step runs, and a step holds
// at its end until the previous result beat has drained.
// Reset: stored rotation is the identity, time_step is 4294967, output empty.
module rigid_body_orientation_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] omega_x,
  input  logic signed [31:0] omega_y,
  input  logic signed [31:0] omega_z,
  input  logic               restart_identity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rot_e0,
  output logic signed [31:0] rot_e1,
  output logic signed [31:0] rot_e2,
  output logic signed [31:0] rot_e3,
  output logic signed [31:0] rot_e4,
  output logic signed [31:0] rot_e5,
  output logic signed [31:0] rot_e6,
  output logic signed [31:0] rot_e7,
  output logic signed [31:0] rot_e8,
  output logic signed [31:0] spin_x,
  output logic signed [31:0] spin_y,
  output logic signed [31:0] spin_z
);

  typedef enum logic [4:0] {
    S_IDLE, S_TH, S_SQ, S_DECIDE, S_SQRT, S_DIVQ, S_RR, S_U, S_POLY, S_SR, S_CR,
    S_QUAD, S_DIVK, S_SV, S_W, S_DBUILD, S_PROD, S_SPIN, S_FIN
  } state_t;

  state_t state;

  logic [31:0]        time_step;
  logic signed [31:0] om [3];
  logic signed [63:0] th [3];
  logic [127:0]       angsq;
  logic               big;
  logic signed [63:0] u;
  logic signed [63:0] a_s;
  logic signed [63:0] pacc;
  logic               psel;
  logic [2:0]         pk;
  logic [63:0]        n;
  logic [63:0]        qd;
  logic signed [63:0] rr;
  logic signed [63:0] sr;
  logic signed [63:0] cr;
  logic signed [63:0] sfac;
  logic signed [63:0] wfac;
  rbou_pkg::shift_t   sshift;
  rbou_pkg::shift_t   tshift;
  logic signed [63:0] tmp;
  logic signed [63:0] kv [3];
  logic signed [63:0] sv [3];
  logic signed [63:0] w [6];
  logic signed [63:0] d [9];
  logic signed [31:0] rm [9];
  logic signed [31:0] nr [9];
  logic signed [31:0] spin [3];
  logic signed [31:0] rot_q [9];
  logic signed [31:0] spin_q [3];
  logic signed [63:0] acc;
  logic [1:0]         i2;
  logic [1:0]         r2;
  logic [1:0]         c2;
  logic [2:0]         wp;
  logic               wph;
  logic               mpend;

  // square root
  logic [127:0] sx;
  logic [67:0]  srem;
  logic [63:0]  sroot;
  logic [5:0]   scnt;

  // divider
  logic [63:0] drem;
  logic [63:0] dlo;
  logic [63:0] dquo;
  logic [63:0] dd;
  logic [5:0]  dcnt;
  logic        dpend;
  logic        dovf;

  rbou_pkg::mul_req_t mreq;
  rbou_pkg::mul_rsp_t mrsp;

  rbou_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  logic               in_acc;
  logic [3:0]         ri_idx;
  logic [3:0]         ic_idx;
  logic [3:0]         rc_idx;
  logic [1:0]         wi;
  logic [1:0]         wj;
  logic signed [63:0] pnew;
  logic signed [63:0] psum;
  logic [67:0]        srem_sh;
  logic [67:0]        strial;
  logic               sge;
  logic               dcarry;
  logic [63:0]        drem_sh;
  logic               dge;
  logic [63:0]        dq_fin;
  logic [63:0]        kq;
  logic [63:0]        kq_c;
  logic [63:0]        mth;
  logic signed [63:0] sn;
  logic signed [63:0] cn;
  logic               small_ang;

  function automatic logic signed [31:0] sat30(input logic signed [63:0] s);
    logic signed [63:0] v;
    v = (s + 64'sd536870912) >>> 30;
    if (v < -64'sd1073741824) return -rbou_pkg::UNIT30;
    if (v > 64'sd1073741824) return rbou_pkg::UNIT30;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] s);
    logic signed [63:0] v;
    v = (s + 64'sd536870912) >>> 30;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    return v[31:0];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);

  assign ri_idx = 4'(r2) + 4'(i2) * 4'd3;
  assign ic_idx = 4'(i2) + 4'(c2) * 4'd3;
  assign rc_idx = 4'(r2) + 4'(c2) * 4'd3;

  assign small_ang = (angsq[127:64] == 64'd0) && (angsq[63:0] < rbou_pkg::SMALL_THR);

  always_comb begin
    unique case (wp)
      3'd1: begin wi = 2'd1; wj = 2'd1; end
      3'd2: begin wi = 2'd2; wj = 2'd2; end
      3'd3: begin wi = 2'd0; wj = 2'd1; end
      3'd4: begin wi = 2'd0; wj = 2'd2; end
      3'd5: begin wi = 2'd1; wj = 2'd2; end
      default: begin wi = 2'd0; wj = 2'd0; end
    endcase
  end

  assign pnew = (psel ? rbou_pkg::cos_coef(pk) : rbou_pkg::sin_coef(pk)) + mrsp.res;
  assign psum = acc + mrsp.res;

  // one digit of the restoring square root
  assign srem_sh = {srem[65:0], sx[127:126]};
  assign strial  = {2'b00, sroot, 2'b01};
  assign sge     = (srem_sh >= strial);

  // one bit of the restoring divide
  assign dcarry  = drem[63];
  assign drem_sh = {drem[62:0], dlo[63]};
  assign dge     = dcarry || (drem_sh >= dd);
  assign dq_fin  = {dquo[62:0], dge};
  assign kq      = dovf ? 64'hFFFF_FFFF_FFFF_FFFF : dq_fin;
  assign kq_c    = (kq > rbou_pkg::KMAX) ? rbou_pkg::KMAX : kq;
  assign mth     = rbou_pkg::mag64(th[i2]);

  always_comb begin
    unique case (qd[1:0])
      2'd0: begin sn = sr;  cn = cr;  end
      2'd1: begin sn = cr;  cn = -sr; end
      2'd2: begin sn = -sr; cn = -cr; end
      default: begin sn = -cr; cn = sr; end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.sh    = rbou_pkg::SH_0;
    unique case (state)
      S_TH: begin
        mreq.a = {32'b0, time_step};
        mreq.b = 64'(om[i2]);
      end
      S_SQ: begin
        mreq.a = th[i2];
        mreq.b = th[i2];
      end
      S_DIVQ: begin
        // quadrant by reciprocal multiplication
        mreq.a = n + rbou_pkg::HP30_H;
        mreq.b = rbou_pkg::QRECIP;
      end
      S_RR: begin
        mreq.a = qd;
        mreq.b = rbou_pkg::HP60;
      end
      S_U: begin
        mreq.a  = rr;
        mreq.b  = rr;
        mreq.sh = rbou_pkg::SH_60;
      end
      S_POLY: begin
        mreq.a  = pacc;
        mreq.b  = u;
        mreq.sh = rbou_pkg::SH_60;
      end
      S_SR: begin
        mreq.a  = rr;
        mreq.b  = a_s;
        mreq.sh = rbou_pkg::SH_60;
      end
      S_CR: begin
        mreq.a  = u;
        mreq.b  = pacc;
        mreq.sh = rbou_pkg::SH_60;
      end
      S_SV: begin
        mreq.a  = sfac;
        mreq.b  = kv[i2];
        mreq.sh = sshift;
      end
      S_W: begin
        if (wph) begin
          mreq.a  = wfac;
          mreq.b  = tmp;
          mreq.sh = rbou_pkg::SH_60;
        end else begin
          mreq.a  = kv[wi];
          mreq.b  = kv[wj];
          mreq.sh = tshift;
        end
      end
      S_PROD: begin
        mreq.a  = 64'(rm[ri_idx]);
        mreq.b  = d[ic_idx];
        mreq.sh = rbou_pkg::SH_30;
      end
      S_SPIN: begin
        mreq.a = 64'(nr[ri_idx]);
        mreq.b = 64'(om[i2]);
      end
      default: ;
    endcase
    if (state == S_TH || state == S_SQ || state == S_DIVQ || state == S_RR ||
        state == S_U || state == S_POLY || state == S_SR || state == S_CR ||
        state == S_SV || state == S_W || state == S_PROD || state == S_SPIN) begin
      mreq.start = !mpend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      time_step <= 32'd4294967;
      out_valid <= 1'b0;
      mpend     <= 1'b0;
      dpend     <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        rm[k] <= (k % 4 == 0) ? rbou_pkg::UNIT30 : 32'sd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) time_step <= cfg_data;
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      if (mreq.start) mpend <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            om[0] <= omega_x;
            om[1] <= omega_y;
            om[2] <= omega_z;
            if (restart_identity) begin
              for (int k = 0; k < 9; k++) begin
                rm[k] <= (k % 4 == 0) ? rbou_pkg::UNIT30 : 32'sd0;
              end
            end
            angsq <= '0;
            i2    <= '0;
            state <= S_TH;
          end
        end
        S_TH: begin
          if (mpend && mrsp.done) begin
            mpend     <= 1'b0;
            th[i2]    <= (mrsp.res + 64'sd131072) >>> 18;
            if (i2 == 2'd2) begin
              i2    <= '0;
              state <= S_SQ;
            end else begin
              i2 <= i2 + 2'd1;
            end
          end
        end
        S_SQ: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            angsq <= angsq + mrsp.raw;
            if (i2 == 2'd2) begin
              i2    <= '0;
              state <= S_DECIDE;
            end else begin
              i2 <= i2 + 2'd1;
            end
          end
        end
        S_DECIDE: begin
          big <= !small_ang;
          if (small_ang) begin
            u     <= angsq[63:0];
            kv    <= th;
            psel  <= 1'b0;
            pk    <= 3'd5;
            pacc  <= rbou_pkg::sin_coef(3'd6);
            state <= S_POLY;
          end else begin
            sx    <= angsq;
            srem  <= '0;
            sroot <= '0;
            scnt  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem  <= sge ? srem_sh - strial : srem_sh;
          sroot <= {sroot[62:0], sge};
          sx    <= {sx[125:0], 2'b00};
          scnt  <= scnt + 6'd1;
          if (scnt == 6'd63) begin
            n     <= {sroot[62:0], sge};
            state <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            qd    <= {14'b0, mrsp.raw[127:78]};
            state <= S_RR;
          end
        end
        S_DIVK: begin
          if (!dpend) begin
            dpend <= 1'b1;
            dcnt  <= '0;
            dquo  <= '0;
            drem  <= {4'b0, mth[63:4]};
            dlo   <= {mth[3:0], 60'b0};
            dd    <= n;
            dovf  <= ({4'b0, mth[63:4]} >= n);
          end else begin
            drem <= dge ? drem_sh - dd : drem_sh;
            dlo  <= {dlo[62:0], 1'b0};
            dquo <= dq_fin;
            dcnt <= dcnt + 6'd1;
            if (dcnt == 6'd63) begin
              dpend  <= 1'b0;
              kv[i2] <= th[i2][63] ? -$signed(kq_c) : $signed(kq_c);
              if (i2 == 2'd2) begin
                i2    <= '0;
                state <= S_SV;
              end else begin
                i2 <= i2 + 2'd1;
              end
            end
          end
        end
        S_RR: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            rr    <= $signed((n << 30) - mrsp.raw[63:0]);
            state <= S_U;
          end
        end
        S_U: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            u     <= mrsp.res;
            psel  <= 1'b0;
            pk    <= 3'd5;
            pacc  <= rbou_pkg::sin_coef(3'd6);
            state <= S_POLY;
          end
        end
        S_POLY: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            if (pk != 3'd0) begin
              pacc <= pnew;
              pk   <= pk - 3'd1;
            end else if (!psel) begin
              a_s  <= pnew;
              psel <= 1'b1;
              pk   <= 3'd5;
              pacc <= rbou_pkg::cos_coef(3'd6);
            end else if (big) begin
              // hold the cosine polynomial in pacc for the S_CR multiply
              pacc  <= pnew;
              state <= S_SR;
            end else begin
              sfac   <= a_s;
              wfac   <= pnew;
              sshift <= rbou_pkg::SH_30;
              tshift <= rbou_pkg::SH_0;
              i2     <= '0;
              state  <= S_SV;
            end
          end
        end
        S_SR: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            sr    <= mrsp.res;
            state <= S_CR;
          end
        end
        S_CR: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            cr    <= rbou_pkg::ONE - mrsp.res;
            state <= S_QUAD;
          end
        end
        S_QUAD: begin
          sfac   <= sn;
          wfac   <= rbou_pkg::ONE - cn;
          sshift <= rbou_pkg::SH_60;
          tshift <= rbou_pkg::SH_60;
          i2     <= '0;
          state  <= S_DIVK;
        end
        S_SV: begin
          if (mpend && mrsp.done) begin
            mpend  <= 1'b0;
            sv[i2] <= mrsp.res;
            if (i2 == 2'd2) begin
              i2    <= '0;
              wp    <= '0;
              wph   <= 1'b0;
              state <= S_W;
            end else begin
              i2 <= i2 + 2'd1;
            end
          end
        end
        S_W: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            wph   <= !wph;
            if (!wph) begin
              tmp <= mrsp.res;
            end else begin
              w[wp] <= mrsp.res;
              if (wp == 3'd5) state <= S_DBUILD;
              else wp <= wp + 3'd1;
            end
          end
        end
        S_DBUILD: begin
          d[0]  <= rbou_pkg::ONE - w[1] - w[2];
          d[1]  <= w[3] + sv[2];
          d[2]  <= w[4] - sv[1];
          d[3]  <= w[3] - sv[2];
          d[4]  <= rbou_pkg::ONE - w[0] - w[2];
          d[5]  <= w[5] + sv[0];
          d[6]  <= w[4] + sv[1];
          d[7]  <= w[5] - sv[0];
          d[8]  <= rbou_pkg::ONE - w[0] - w[1];
          acc   <= '0;
          i2    <= '0;
          r2    <= '0;
          c2    <= '0;
          state <= S_PROD;
        end
        S_PROD: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            if (i2 == 2'd2) begin
              nr[rc_idx] <= sat30(psum);
              acc        <= '0;
              i2         <= '0;
              if (r2 == 2'd2) begin
                r2 <= '0;
                if (c2 == 2'd2) begin
                  c2    <= '0;
                  state <= S_SPIN;
                end else begin
                  c2 <= c2 + 2'd1;
                end
              end else begin
                r2 <= r2 + 2'd1;
              end
            end else begin
              acc <= psum;
              i2  <= i2 + 2'd1;
            end
          end
        end
        S_SPIN: begin
          if (mpend && mrsp.done) begin
            mpend <= 1'b0;
            if (i2 == 2'd2) begin
              spin[r2] <= sat32(psum);
              acc      <= '0;
              i2       <= '0;
              if (r2 == 2'd2) state <= S_FIN;
              else r2 <= r2 + 2'd1;
            end else begin
              acc <= psum;
              i2  <= i2 + 2'd1;
            end
          end
        end
        S_FIN: begin
          // wait for the output register to drain
          if (!out_valid || !out_stall) begin
            rot_q     <= nr;
            spin_q    <= spin;
            rm        <= nr;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rot_e0 = rot_q[0];
  assign rot_e1 = rot_q[1];
  assign rot_e2 = rot_q[2];
  assign rot_e3 = rot_q[3];
  assign rot_e4 = rot_q[4];
  assign rot_e5 = rot_q[5];
  assign rot_e6 = rot_q[6];
  assign rot_e7 = rot_q[7];
  assign rot_e8 = rot_q[8];
  assign spin_x = spin_q[0];
  assign spin_y = spin_q[1];
  assign spin_z = spin_q[2];

endmodule

@@ rtl/rbou_mul.sv @@
// Iterative signed 64x64 multiplier: four 32x32 partial products, then round, shift, saturate.
module rbou_mul (
  input  logic               clk,
  input  logic               rst,
  input  rbou_pkg::mul_req_t req,
  output rbou_pkg::mul_rsp_t rsp
);

  logic [63:0]        ma;
  logic [63:0]        mb;
  logic               neg;
  rbou_pkg::shift_t   shc;
  logic [127:0]       acc;
  logic               busy;
  logic [2:0]         cnt;
  logic signed [63:0] res;
  logic               done;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [128:0] rnd;
  logic [63:0]  mg;
  logic signed [63:0] fin;

  always_comb begin
    pa = cnt[1] ? ma[63:32] : ma[31:0];
    pb = cnt[0] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    unique case (cnt[1:0])
      2'b00: pp_sh = {64'b0, pp};
      2'b01: pp_sh = {32'b0, pp, 32'b0};
      2'b10: pp_sh = {32'b0, pp, 32'b0};
      2'b11: pp_sh = {pp, 64'b0};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    unique case (shc)
      rbou_pkg::SH_30: rnd = ({1'b0, acc} + (129'd1 << 29)) >> 30;
      rbou_pkg::SH_60: rnd = ({1'b0, acc} + (129'd1 << 59)) >> 60;
      default:         rnd = {1'b0, acc};
    endcase
    mg  = (|rnd[128:63]) ? 64'(rbou_pkg::INT64_MAX) : rnd[63:0];
    fin = neg ? -$signed(mg) : $signed(mg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        ma   <= rbou_pkg::mag64(req.a);
        mb   <= rbou_pkg::mag64(req.b);
        neg  <= req.a[63] ^ req.b[63];
        shc  <= req.sh;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == 3'd4) begin
        res  <= fin;
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        done <= 1'b0;
        if (busy) begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;
  assign rsp.raw  = acc;

endmodule
